FILE: design/pla_pkg.sv
package pla_pkg;

    // table geometry: ENTRIES entries held GROUP to a cell in a row of CELLS cells
    localparam int ENTRIES = 256;
    localparam int GROUP   = 8;
    localparam int CELLS   = (ENTRIES + GROUP - 1) / GROUP;
    localparam int GRP_W   = $clog2(GROUP);
    localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IDX_W   = CELL_W + GRP_W;
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int COLOR_W = 24;

    localparam logic CMD_PRELOAD = 1'b0;
    localparam logic CMD_ALLOC   = 1'b1;

    localparam logic [1:0] STAT_MATCH   = 2'd0;
    localparam logic [1:0] STAT_NEW     = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_PRELOAD = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PUSH
    } state_t;

    // running search result handed from cell to cell
    typedef struct packed {
        logic             matched;
        logic [IDX_W-1:0] match_idx;
        logic             have_free;
        logic [IDX_W-1:0] free_idx;
    } srch_t;

    // entry write broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
        logic               free;
    } wr_t;

endpackage

FILE: design/pla_cell.sv
module pla_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pla_pkg::CELL_W-1:0]    cell_id,
    input  pla_pkg::wr_t                  wr,
    input  logic [pla_pkg::COLOR_W-1:0]   key,
    input  pla_pkg::srch_t                srch_in,
    output pla_pkg::srch_t                srch_out
);

    logic [pla_pkg::COLOR_W-1:0] color_reg [pla_pkg::GROUP];
    logic [pla_pkg::GROUP-1:0]   free_reg;
    pla_pkg::srch_t              srch_reg;
    pla_pkg::srch_t              srch_next;

    logic                        local_hit;
    logic [pla_pkg::IDX_W-1:0]   local_hit_idx;
    logic                        local_free;
    logic [pla_pkg::IDX_W-1:0]   local_free_idx;
    logic [pla_pkg::GROUP-1:0]   ent_exists;
    logic [pla_pkg::IDX_W-1:0]   ent_idx [pla_pkg::GROUP];

    always_comb
    begin
        for (int j = 0; j < pla_pkg::GROUP; j++)
        begin
            ent_idx[j]    = {cell_id, pla_pkg::GRP_W'(j)};
            // slots past the end of the table in the last cell never take part
            ent_exists[j] = (32'(ent_idx[j]) < 32'(pla_pkg::ENTRIES));
        end
    end

    // lowest-index hit and lowest-index free entry within this cell
    always_comb
    begin
        local_hit      = 1'b0;
        local_hit_idx  = '0;
        local_free     = 1'b0;
        local_free_idx = '0;
        for (int j = pla_pkg::GROUP - 1; j >= 0; j--)
        begin
            if (ent_exists[j] && free_reg[j])
            begin
                local_free     = 1'b1;
                local_free_idx = ent_idx[j];
            end
            if (ent_exists[j] && !free_reg[j] && (color_reg[j] == key))
            begin
                local_hit     = 1'b1;
                local_hit_idx = ent_idx[j];
            end
        end
    end

    // earlier cells hold lower indexes, so their findings win
    always_comb
    begin
        srch_next = srch_in;
        if (!srch_in.matched && local_hit)
        begin
            srch_next.matched   = 1'b1;
            srch_next.match_idx = local_hit_idx;
        end
        if (!srch_in.have_free && local_free)
        begin
            srch_next.have_free = 1'b1;
            srch_next.free_idx  = local_free_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_reg <= '0;
            free_reg <= '0;
            for (int j = 0; j < pla_pkg::GROUP; j++)
            begin
                color_reg[j] <= '0;
            end
        end
        else
        begin
            srch_reg <= srch_next;
            for (int j = 0; j < pla_pkg::GROUP; j++)
            begin
                if (wr.en && (wr.idx == ent_idx[j]))
                begin
                    color_reg[j] <= wr.color;
                    free_reg[j]  <= wr.free;
                end
            end
        end
    end

    assign srch_out = srch_reg;

endmodule

FILE: design/palette_lookup_or_allocate.sv
// preload: the entry is written as the request is accepted; allocate: the key is registered
//   and the search walks the row of 32 cells, 8 entries each, one per cycle; both then go
//   through the push state into the result register and take no new request before idle
// the result register frees the input side while a result waits to be taken
// reset (rst_n low, asynchronous) clears every entry to black and in use
module palette_lookup_or_allocate
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       req_valid,
    output logic       req_stall,
    input  logic       cmd,
    input  logic [7:0] slot,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       mark_free,

    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] index,
    output logic [1:0] status
);

    pla_pkg::state_t               state_reg;
    pla_pkg::state_t               state_next;
    logic [pla_pkg::CNT_W-1:0]     cnt_reg;
    logic [pla_pkg::CNT_W-1:0]     cnt_next;
    logic [pla_pkg::COLOR_W-1:0]   key_reg;
    logic [pla_pkg::COLOR_W-1:0]   key_next;
    logic [7:0]                    pend_idx_reg;
    logic [7:0]                    pend_idx_next;
    logic [1:0]                    pend_st_reg;
    logic [1:0]                    pend_st_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [7:0]                    out_idx_reg;
    logic [7:0]                    out_idx_next;
    logic [1:0]                    out_st_reg;
    logic [1:0]                    out_st_next;

    pla_pkg::wr_t                  wr;
    pla_pkg::srch_t                chain [pla_pkg::CELLS + 1];
    pla_pkg::srch_t                found;

    assign chain[0] = '0;

    for (genvar k = 0; k < pla_pkg::CELLS; k++)
    begin : g_cell
        pla_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_id  (pla_pkg::CELL_W'(k)),
            .wr       (wr),
            .key      (key_reg),
            .srch_in  (chain[k]),
            .srch_out (chain[k + 1])
        );
    end

    assign found = chain[pla_pkg::CELLS];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        pend_idx_next  = pend_idx_reg;
        pend_st_next   = pend_st_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_st_next    = out_st_reg;
        wr             = '0;
        req_stall      = (state_reg != pla_pkg::ST_IDLE);

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pla_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (cmd == pla_pkg::CMD_PRELOAD)
                    begin
                        wr.en         = (32'(slot) < 32'(pla_pkg::ENTRIES));
                        wr.idx        = pla_pkg::IDX_W'(slot);
                        wr.color      = {red, green, blue};
                        wr.free       = mark_free;
                        pend_idx_next = slot;
                        pend_st_next  = pla_pkg::STAT_PRELOAD;
                        state_next    = pla_pkg::ST_PUSH;
                    end
                    else
                    begin
                        key_next   = {red, green, blue};
                        cnt_next   = '0;
                        state_next = pla_pkg::ST_SEARCH;
                    end
                end
            end
            pla_pkg::ST_SEARCH:
            begin
                // last cell holds the full answer once every cell has seen the key
                if (cnt_reg == pla_pkg::CNT_W'(pla_pkg::CELLS))
                begin
                    if (found.matched)
                    begin
                        pend_idx_next = 8'(found.match_idx);
                        pend_st_next  = pla_pkg::STAT_MATCH;
                    end
                    else if (found.have_free)
                    begin
                        wr.en         = 1'b1;
                        wr.idx        = found.free_idx;
                        wr.color      = key_reg;
                        wr.free       = 1'b0;
                        pend_idx_next = 8'(found.free_idx);
                        pend_st_next  = pla_pkg::STAT_NEW;
                    end
                    else
                    begin
                        pend_idx_next = '0;
                        pend_st_next  = pla_pkg::STAT_FULL;
                    end
                    state_next = pla_pkg::ST_PUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pla_pkg::ST_PUSH:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = pend_idx_reg;
                    out_st_next    = pend_st_reg;
                    state_next     = pla_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pla_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pla_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pend_idx_reg <= pend_idx_next;
        pend_st_reg  <= pend_st_next;
        out_idx_reg  <= out_idx_next;
        out_st_reg   <= out_st_next;
    end

    assign res_valid = out_valid_reg;
    assign index     = out_idx_reg;
    assign status    = out_st_reg;

endmodule
